// ===== src/apm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the audio peak level meter.
// Used by every module under src; depends on nothing.
package apm_pkg;

  localparam int SAMPLE_SIZE_W   = 6;
  localparam int SAMPLE_KIND_W   = 2;
  localparam int CHANNEL_COUNT_W = 4;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 6;

  localparam int PEAK_W  = 32;
  localparam int LEVEL_W = 18;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_SIZE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_KIND     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CAPTURE_ENABLED = 2'd3;

  localparam logic [SAMPLE_SIZE_W-1:0]   SAMPLE_SIZE_RESET   = 6'd16;
  localparam logic [SAMPLE_KIND_W-1:0]   SAMPLE_KIND_RESET   = 2'd0;
  localparam logic [CHANNEL_COUNT_W-1:0] CHANNEL_COUNT_RESET = 4'd2;

  // Sample kinds.
  localparam logic [SAMPLE_KIND_W-1:0] KIND_SIGNED   = 2'd0;
  localparam logic [SAMPLE_KIND_W-1:0] KIND_UNSIGNED = 2'd1;
  localparam logic [SAMPLE_KIND_W-1:0] KIND_FLOAT    = 2'd2;
  localparam logic [SAMPLE_KIND_W-1:0] KIND_OTHER    = 2'd3;

  // Level saturates at 2.0 in Q2.16.
  localparam logic [LEVEL_W-1:0] LEVEL_SAT = 18'd131072;

  // Quotient bits produced by the divider, one per cycle.
  localparam int DIV_STEPS = 17;

  localparam int JOB_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    SZ_NONE,
    SZ_8,
    SZ_16,
    SZ_32
  } size_code_t;

  typedef struct packed {
    logic [SAMPLE_SIZE_W-1:0]   sample_size;
    logic [SAMPLE_KIND_W-1:0]   sample_kind;
    logic [CHANNEL_COUNT_W-1:0] channel_count;
    logic                       capture_enabled;
  } cfg_t;

  // One finished buffer, handed from the byte front end to the divider.
  typedef struct packed {
    logic              active;
    size_code_t        size;
    logic              unsigned_scale;
    logic [PEAK_W-1:0] peak;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// ===== src/apm_queue.sv =====
`timescale 1ns / 1ps
// Short request queue between the byte front end and the level divider.
// Depends on apm_pkg for the job type and the queue depth.
module apm_queue
  import apm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  job_t          push_job,
  input  logic          pop,
  output job_t          pop_job,
  output queue_status_t status
);

  localparam int PTR_W = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOB_QUEUE_DEPTH + 1);

  job_t             entries [JOB_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(JOB_QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(JOB_QUEUE_DEPTH));
  assign pop_job      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!status.full || pop))
    else $error("request pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("request popped from an empty queue");

endmodule

// ===== src/apm_front.sv =====
`timescale 1ns / 1ps
// Byte front end: assembles samples, takes magnitudes and tracks the frame
// and buffer peaks. Depends on apm_pkg; feeds apm_queue.
module apm_front
  import apm_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  output logic        push,
  output job_t        push_job
);

  localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = ($clog2(MAX_CHANNELS + 1) > CHANNEL_COUNT_W) ?
                         $clog2(MAX_CHANNELS + 1) : CHANNEL_COUNT_W;

  logic [31:0]       sample_shift;
  logic [1:0]        byte_position;
  logic [POS_W-1:0]  channel_position;
  logic [PEAK_W-1:0] frame_peak;
  logic [PEAK_W-1:0] buffer_peak;

  logic [31:0]       sample_shift_next;
  logic [1:0]        byte_position_next;
  logic [POS_W-1:0]  channel_position_next;
  logic [PEAK_W-1:0] frame_peak_next;
  logic [PEAK_W-1:0] buffer_peak_next;

  size_code_t        size;
  logic [2:0]        nbytes;
  logic [CNT_W-1:0]  chan_eff;
  logic [CNT_W-1:0]  count_ext;
  logic [31:0]       shift_or;
  logic [31:0]       raw;
  logic [PEAK_W-1:0] mag;
  logic [PEAK_W-1:0] frame_upd;
  logic [PEAK_W-1:0] buffer_upd;
  logic [PEAK_W-1:0] peak_at_end;
  logic              sample_done;
  logic              frame_done;

  // |x| * 2^31 of a single-precision float, truncated and saturated.
  function automatic logic [31:0] float_mag(input logic [31:0] bits);
    logic [7:0]  e;
    logic [22:0] m;
    logic [23:0] mant;
    logic [7:0]  sh;
    e    = bits[30:23];
    m    = bits[22:0];
    mant = {1'b1, m};
    if (e == 8'hff) begin
      return (m != '0) ? 32'd0 : 32'hffff_ffff;
    end
    if (e == 8'd0) begin
      return 32'd0;
    end
    if (e >= 8'd119) begin
      sh = e - 8'd119;
      if (sh > 8'd8) begin
        return 32'hffff_ffff;
      end
      return 32'(mant) << sh[3:0];
    end
    sh = 8'd119 - e;
    if (sh >= 8'd24) begin
      return 32'd0;
    end
    return 32'(mant) >> sh[4:0];
  endfunction

  function automatic logic [PEAK_W-1:0] sample_mag(input logic [31:0] r,
                                                   input size_code_t sz,
                                                   input logic [SAMPLE_KIND_W-1:0] kind);
    logic [PEAK_W-1:0] res;
    res = r;
    case (kind)
      KIND_UNSIGNED: res = r;
      KIND_FLOAT:    res = (sz == SZ_32) ? float_mag(r) : '0;
      KIND_OTHER:    res = '0;
      default: begin
        // The most negative 8- or 16-bit value keeps a carry above its width.
        case (sz)
          SZ_8:    res = r[7] ? 32'(9'h100 - {1'b0, r[7:0]}) +
                                ((r[7:0] == 8'h80) ? 32'h100 : 32'h0) : r;
          SZ_16:   res = r[15] ? 32'(17'h1_0000 - {1'b0, r[15:0]}) +
                                 ((r[15:0] == 16'h8000) ? 32'h1_0000 : 32'h0) : r;
          default: res = r[31] ? (32'd0 - r) : r;
        endcase
      end
    endcase
    return res;
  endfunction

  always_comb begin
    unique case (cfg.sample_size)
      6'd8:    size = SZ_8;
      6'd16:   size = SZ_16;
      6'd32:   size = SZ_32;
      default: size = SZ_NONE;
    endcase
  end

  always_comb begin
    unique case (size)
      SZ_8:    nbytes = 3'd1;
      SZ_16:   nbytes = 3'd2;
      SZ_32:   nbytes = 3'd4;
      default: nbytes = 3'd0;
    endcase
  end

  // A count of zero means one channel; counts past the limit are clamped.
  always_comb begin
    count_ext = CNT_W'(cfg.channel_count);
    if (count_ext == '0) begin
      chan_eff = CNT_W'(1);
    end else if (count_ext > CNT_W'(MAX_CHANNELS)) begin
      chan_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      chan_eff = count_ext;
    end
  end

  always_comb begin
    shift_or    = sample_shift | (32'(data_byte) << {byte_position, 3'b000});
    sample_done = ({1'b0, byte_position} + 3'd1) >= nbytes;
    frame_done  = (CNT_W'(channel_position) + CNT_W'(1)) >= chan_eff;

    case (size)
      SZ_8:    raw = {24'd0, shift_or[7:0]};
      SZ_16:   raw = {16'd0, shift_or[15:0]};
      default: raw = shift_or;
    endcase

    mag        = sample_mag(raw, size, cfg.sample_kind);
    frame_upd  = (mag > frame_peak) ? mag : frame_peak;
    buffer_upd = (frame_upd > buffer_peak) ? frame_upd : buffer_peak;

    sample_shift_next     = sample_shift;
    byte_position_next    = byte_position;
    channel_position_next = channel_position;
    frame_peak_next       = frame_peak;
    buffer_peak_next      = buffer_peak;

    if (accept && size != SZ_NONE) begin
      if (sample_done) begin
        sample_shift_next  = '0;
        byte_position_next = '0;
        if (frame_done) begin
          buffer_peak_next      = buffer_upd;
          frame_peak_next       = '0;
          channel_position_next = '0;
        end else begin
          frame_peak_next       = frame_upd;
          channel_position_next = channel_position + 1'b1;
        end
      end else begin
        sample_shift_next  = shift_or;
        byte_position_next = byte_position + 2'd1;
      end
    end

    peak_at_end = buffer_peak_next;

    // A buffer end drops any partial sample or frame.
    if (accept && buffer_end) begin
      sample_shift_next     = '0;
      byte_position_next    = '0;
      channel_position_next = '0;
      frame_peak_next       = '0;
      buffer_peak_next      = '0;
    end
  end

  assign push                    = accept && buffer_end;
  assign push_job.active         = cfg.capture_enabled && (size != SZ_NONE);
  assign push_job.size           = size;
  assign push_job.unsigned_scale = (cfg.sample_kind == KIND_UNSIGNED);
  assign push_job.peak           = peak_at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_shift     <= '0;
      byte_position    <= '0;
      channel_position <= '0;
      frame_peak       <= '0;
      buffer_peak      <= '0;
    end else begin
      sample_shift     <= sample_shift_next;
      byte_position    <= byte_position_next;
      channel_position <= channel_position_next;
      frame_peak       <= frame_peak_next;
      buffer_peak      <= buffer_peak_next;
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (accept && buffer_end) |=> (byte_position == '0 && channel_position == '0 &&
                                frame_peak == '0 && buffer_peak == '0))
    else $error("front state not cleared after a buffer end");

endmodule

// ===== src/apm_back.sv =====
`timescale 1ns / 1ps
// Level back end: divides the buffer peak by full scale one quotient bit per
// cycle, holds the last level and registers the result. Depends on apm_pkg.
module apm_back
  import apm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  queue_status_t      status,
  input  job_t               pop_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LEVEL_W-1:0] level_q16,
  output logic [PEAK_W-1:0]  peak_value
);

  localparam int STEP_W = $clog2(DIV_STEPS);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  state_t              state;
  logic [31:0]         rem;
  logic [31:0]         divisor;
  logic [DIV_STEPS-1:0] quo;
  logic [STEP_W-1:0]   step;
  logic [PEAK_W-1:0]   peak_hold;
  logic [LEVEL_W-1:0]  held_level;

  logic [31:0]         scale;
  logic                sat;
  logic [32:0]         trial;
  logic                ge;
  logic [31:0]         rem_next;
  logic [DIV_STEPS-1:0] quo_next;

  function automatic logic [31:0] full_scale(input size_code_t sz, input logic uns);
    logic [31:0] s;
    unique case (sz)
      SZ_8:    s = uns ? 32'd255 : 32'd127;
      SZ_16:   s = uns ? 32'd65535 : 32'd32767;
      SZ_32:   s = uns ? 32'hffff_ffff : 32'h7fff_ffff;
      default: s = 32'd0;
    endcase
    return s;
  endfunction

  assign pop   = (state == ST_IDLE) && !status.empty && (!out_valid || !out_stall);
  assign scale = full_scale(pop_job.size, pop_job.unsigned_scale);
  // Quotient would reach 2.0 or more.
  assign sat   = {1'b0, pop_job.peak} >= {scale, 1'b0};

  // The first step works on the peak itself, later ones on the doubled remainder.
  always_comb begin
    trial    = (step == '0) ? {1'b0, rem} : {rem, 1'b0};
    ge       = trial >= {1'b0, divisor};
    rem_next = ge ? 32'(trial - {1'b0, divisor}) : trial[31:0];
    quo_next = {quo[DIV_STEPS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      held_level <= '0;
      step       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop && !pop_job.active) begin
            out_valid  <= 1'b1;
            level_q16  <= held_level;
            peak_value <= '0;
          end else if (pop && sat) begin
            out_valid  <= 1'b1;
            held_level <= LEVEL_SAT;
            level_q16  <= LEVEL_SAT;
            peak_value <= pop_job.peak;
          end else begin
            if (out_valid && !out_stall) begin
              out_valid <= 1'b0;
            end
            if (pop) begin
              rem       <= pop_job.peak;
              divisor   <= scale;
              quo       <= '0;
              step      <= '0;
              peak_hold <= pop_job.peak;
              state     <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          // The result register is always empty here, see a_div_no_result.
          rem  <= rem_next;
          quo  <= quo_next;
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            out_valid  <= 1'b1;
            held_level <= LEVEL_W'(quo_next);
            level_q16  <= LEVEL_W'(quo_next);
            peak_value <= peak_hold;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_div_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !out_valid)
    else $error("result register busy while dividing");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level_q16 <= LEVEL_SAT))
    else $error("level above saturation");

endmodule

// ===== src/audio_peak_level_meter.sv =====
`timescale 1ns / 1ps
// Audio peak level meter, top level. Holds the configuration registers and
// joins apm_front, apm_queue and apm_back. Depends on apm_pkg.
//
// Input channel: one raw buffer byte per request (data_byte), buffer_end high
// on the buffer's last byte. A byte is taken on a clock edge where in_valid
// is high and in_stall is low; the front end takes one byte per such cycle.
// in_stall rises only when the two-entry queue of finished buffers is full.
// Output channel: one result per buffer end, level_q16 (Q2.16, up to 2.0)
// and peak_value, taken where out_valid is high and out_stall is low.
// Buffer ends go through the queue; the back end registers the result at once
// when metering is off or the level saturates, else its restoring divider
// yields one quotient bit per cycle and takes no new buffer meanwhile. While
// the receiver stalls, the result register holds and further buffer ends wait
// in the queue; bytes keep flowing until it fills. Configuration must be
// written through cfg_write, cfg_index and cfg_data only while the block is
// idle; the block does not enforce it. Synchronous reset restores the register
// defaults (16-bit signed, two channels, capture off), empties the queue,
// clears the held level and drops any partial sample, frame or result.
module audio_peak_level_meter
  import apm_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   buffer_end,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [LEVEL_W-1:0]     level_q16,
  output logic [PEAK_W-1:0]      peak_value
);

  cfg_t          cfg;
  logic          accept;
  logic          push;
  job_t          push_job;
  logic          pop;
  job_t          pop_job;
  queue_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_size     <= SAMPLE_SIZE_RESET;
      cfg.sample_kind     <= SAMPLE_KIND_RESET;
      cfg.channel_count   <= CHANNEL_COUNT_RESET;
      cfg.capture_enabled <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SAMPLE_SIZE:     cfg.sample_size     <= cfg_data[SAMPLE_SIZE_W-1:0];
        REG_SAMPLE_KIND:     cfg.sample_kind     <= cfg_data[SAMPLE_KIND_W-1:0];
        REG_CHANNEL_COUNT:   cfg.channel_count   <= cfg_data[CHANNEL_COUNT_W-1:0];
        REG_CAPTURE_ENABLED: cfg.capture_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = status.full;
  assign accept   = in_valid && !in_stall;

  apm_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (data_byte),
    .buffer_end(buffer_end),
    .push      (push),
    .push_job  (push_job)
  );

  apm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .pop_job (pop_job),
    .status  (status)
  );

  apm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .level_q16 (level_q16),
    .peak_value(peak_value)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for audio_peak_level_meter: streams raw buffer bytes under several
// register settings and checks every level result against a local predictor.
// Depends on apm_pkg and audio_peak_level_meter.
module testbench;
  import apm_pkg::*;

  localparam int MAX_CHANNELS  = 8;
  localparam int RANDOM_BYTES  = 900;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [PEAK_W-1:0]  peak;
  } meter_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = REG_SAMPLE_SIZE;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  logic                   in_stall;
  logic [7:0]             data_byte  = '0;
  logic                   buffer_end = 1'b0;
  logic                   out_valid;
  logic                   out_stall  = 1'b0;
  logic [LEVEL_W-1:0]     level_q16;
  logic [PEAK_W-1:0]      peak_value;

  logic idle_on     = 1'b1;
  logic hold_output = 1'b0;
  int   error_count    = 0;
  int   cycle_count    = 0;
  int   bytes_accepted = 0;

  meter_result_t pending_levels[$];

  // Predictor copy of the registers and of the metering state.
  logic [SAMPLE_SIZE_W-1:0]   size_reg;
  logic [SAMPLE_KIND_W-1:0]   kind_reg;
  logic [CHANNEL_COUNT_W-1:0] chans_reg;
  logic                       capture_reg;
  logic [31:0]                shift_acc;
  logic [1:0]                 byte_pos;
  logic [2:0]                 chan_pos;
  logic [31:0]                frame_max;
  logic [31:0]                buffer_max;
  logic [LEVEL_W-1:0]         level_held;

  audio_peak_level_meter #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .buffer_end(buffer_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .level_q16 (level_q16),
    .peak_value(peak_value)
  );

  function automatic int bytes_per_sample(logic [SAMPLE_SIZE_W-1:0] size);
    case (size)
      6'd8:    return 1;
      6'd16:   return 2;
      6'd32:   return 4;
      default: return 0;
    endcase
  endfunction

  function automatic int effective_channels();
    if (chans_reg == 0) return 1;
    if (chans_reg > MAX_CHANNELS) return MAX_CHANNELS;
    return int'(chans_reg);
  endfunction

  function automatic logic [31:0] full_scale(int nbytes);
    logic uns;
    uns = (kind_reg == KIND_UNSIGNED);
    case (nbytes)
      1:       return uns ? 32'd255 : 32'd127;
      2:       return uns ? 32'd65535 : 32'd32767;
      default: return uns ? 32'hffff_ffff : 32'h7fff_ffff;
    endcase
  endfunction

  function automatic logic [31:0] float_magnitude(logic [31:0] bits);
    logic [7:0]  expo;
    logic [22:0] frac;
    logic [31:0] mant;
    expo = bits[30:23];
    frac = bits[22:0];
    mant = {8'd0, 1'b1, frac};
    if (expo == 8'hff) return (frac != 0) ? 32'd0 : 32'hffff_ffff;
    if (expo == 8'h00) return 32'd0;
    // An exponent of 127 (1.0) moves the hidden bit up to bit 31.
    if (expo >= 8'd119) begin
      if (int'(expo) - 119 > 8) return 32'hffff_ffff;
      return mant << (int'(expo) - 119);
    end
    if (119 - int'(expo) >= 24) return 32'd0;
    return mant >> (119 - int'(expo));
  endfunction

  function automatic logic [31:0] sample_magnitude(logic [31:0] raw, int nbytes);
    case (kind_reg)
      KIND_UNSIGNED: return raw;
      KIND_FLOAT:    return (nbytes == 4) ? float_magnitude(raw) : 32'd0;
      KIND_OTHER:    return 32'd0;
      default: begin
        // The most negative value picks up an extra carry above its width.
        if (nbytes == 1)
          return raw[7] ? ((32'd0 - raw) & 32'hff) + ((raw == 32'h80) ? 32'h100 : 32'h0)
                        : raw;
        if (nbytes == 2)
          return raw[15] ? ((32'd0 - raw) & 32'hffff) +
                           ((raw == 32'h8000) ? 32'h10000 : 32'h0)
                         : raw;
        return raw[31] ? 32'd0 - raw : raw;
      end
    endcase
  endfunction

  // Advances the predicted meter by one byte and queues the level result
  // that a buffer end produces.
  function automatic void meter_byte(logic [7:0] data, logic last);
    int            nbytes;
    logic [31:0]   raw;
    logic [31:0]   mag;
    logic [63:0]   scaled;
    meter_result_t res;
    nbytes = bytes_per_sample(size_reg);
    if (nbytes != 0) begin
      shift_acc = shift_acc | ({24'd0, data} << (int'(byte_pos) * 8));
      if (int'(byte_pos) + 1 >= nbytes) begin
        raw = shift_acc;
        if (nbytes == 1) raw = raw & 32'hff;
        else if (nbytes == 2) raw = raw & 32'hffff;
        mag = sample_magnitude(raw, nbytes);
        if (mag > frame_max) frame_max = mag;
        shift_acc = '0;
        byte_pos  = '0;
        if (int'(chan_pos) + 1 >= effective_channels()) begin
          if (frame_max > buffer_max) buffer_max = frame_max;
          frame_max = '0;
          chan_pos  = '0;
        end else begin
          chan_pos = chan_pos + 3'd1;
        end
      end else begin
        byte_pos = byte_pos + 2'd1;
      end
    end
    if (!last) return;
    res.peak = '0;
    if (capture_reg && nbytes != 0) begin
      scaled = {16'd0, buffer_max, 16'd0};
      scaled = scaled / {32'd0, full_scale(nbytes)};
      level_held = (scaled > LEVEL_SAT) ? LEVEL_SAT : scaled[LEVEL_W-1:0];
      res.peak = buffer_max;
    end
    res.level = level_held;
    pending_levels.push_back(res);
    // Partial samples and frames are dropped at every buffer end.
    shift_acc  = '0;
    byte_pos   = '0;
    chan_pos   = '0;
    frame_max  = '0;
    buffer_max = '0;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= hold_output || (idle_on && $urandom_range(99) < 35);
  end

  always @(posedge clk) begin
    meter_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected result, level_q16 %0d, peak_value %0d",
                 $time, level_q16, peak_value);
        error_count++;
      end else begin
        want = pending_levels.pop_front();
        if (level_q16 !== want.level) begin
          $display("%0t: level_q16 expected %0d, actual %0d", $time, want.level, level_q16);
          error_count++;
        end
        if (peak_value !== want.peak) begin
          $display("%0t: peak_value expected %0d, actual %0d", $time, want.peak, peak_value);
          error_count++;
        end
      end
    end
  end

  // One input request; the payload holds until the block takes it.
  task automatic send_byte(input logic [7:0] data, input logic last);
    while (idle_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= data;
    buffer_end <= last;
    do @(posedge clk); while (in_stall);
    meter_byte(data, last);
    bytes_accepted++;
  endtask

  task automatic wait_idle;
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int size, input int kind, input int chans,
                            input bit capture);
    logic [CFG_INDEX_W-1:0] index_list [4];
    logic [CFG_DATA_W-1:0]  value_list [4];
    wait_idle;
    index_list = '{REG_SAMPLE_SIZE, REG_SAMPLE_KIND, REG_CHANNEL_COUNT, REG_CAPTURE_ENABLED};
    value_list = '{CFG_DATA_W'(size), CFG_DATA_W'(kind), CFG_DATA_W'(chans),
                   CFG_DATA_W'(capture)};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= index_list[i];
      cfg_data  <= value_list[i];
      @(posedge clk);
    end
    cfg_write   <= 1'b0;
    size_reg    = size[SAMPLE_SIZE_W-1:0];
    kind_reg    = kind[SAMPLE_KIND_W-1:0];
    chans_reg   = chans[CHANNEL_COUNT_W-1:0];
    capture_reg = capture;
  endtask

  function automatic logic [31:0] pick_sample(int nbytes);
    logic [31:0] value;
    value = $urandom;
    if (kind_reg == KIND_FLOAT && nbytes == 4) begin
      case ($urandom_range(0, 9))
        0:       value = {value[31], 8'hff, 23'($urandom_range(1, 23'h7fffff))};
        1:       value = {value[31], 8'hff, 23'd0};
        2:       value[30:23] = 8'h00;
        3:       value[30:0] = '0;
        4:       value[30:23] = 8'($urandom_range(127, 128));
        5:       value[30:23] = 8'($urandom_range(94, 96));
        default: value[30:23] = 8'($urandom_range(97, 127));
      endcase
    end else begin
      case ($urandom_range(0, 7))
        0:       value = '1;
        1:       value = 32'h8000_0000 >> (32 - 8 * nbytes);
        2:       value = 32'h7fff_ffff >> (32 - 8 * nbytes);
        3:       value = '0;
        default: ;
      endcase
    end
    return value;
  endfunction

  // Whole frames of random samples, then a trailing fragment if asked.
  task automatic send_buffer(input int frames, input int partial_bytes);
    int          nbytes;
    int          count;
    logic [31:0] value;
    nbytes = bytes_per_sample(size_reg);
    count  = frames * effective_channels();
    for (int s = 0; s < count; s++) begin
      value = pick_sample(nbytes);
      for (int b = 0; b < nbytes; b++)
        send_byte(value[8*b +: 8], partial_bytes == 0 && s == count - 1 && b == nbytes - 1);
    end
    for (int b = 0; b < partial_bytes; b++)
      send_byte(8'($urandom), b == partial_bytes - 1);
  endtask

  task automatic test_reset_state;
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_signed_bytes;
    set_config(8, KIND_SIGNED, 1, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  task automatic test_channel_counts;
    set_config(8, KIND_UNSIGNED, 0, 1'b1);
    send_byte(8'hff, 1'b1);
    // The fourth byte starts a frame that the buffer end drops.
    set_config(8, KIND_UNSIGNED, 3, 1'b1);
    send_byte(8'h20, 1'b0);
    send_byte(8'h30, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'hff, 1'b1);
  endtask

  task automatic test_float_sample;
    set_config(32, KIND_FLOAT, 1, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hc0, 1'b0);
    send_byte(8'hbf, 1'b1);
  endtask

  task automatic test_metering_off;
    set_config(0, KIND_SIGNED, 1, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b1);
    set_config(8, KIND_UNSIGNED, 1, 1'b0);
    send_byte(8'h10, 1'b1);
  endtask

  task automatic test_size_change_mid_buffer;
    set_config(16, KIND_SIGNED, 1, 1'b1);
    send_byte(8'h34, 1'b0);
    // The half-built sample completes on the next byte once the size is 8.
    set_config(8, KIND_SIGNED, 1, 1'b1);
    send_byte(8'h12, 1'b1);
  endtask

  task automatic test_output_backpressure;
    set_config(8, KIND_UNSIGNED, 1, 1'b1);
    hold_output <= 1'b1;
    fork
      begin
        @(posedge clk iff in_stall);
        hold_output <= 1'b0;
      end
    join_none
    repeat (10) send_byte(8'($urandom), 1'b1);
  endtask

  task automatic test_random_traffic;
    int phase;
    int start;
    int size;
    int kind;
    int frame_bytes;
    phase = 0;
    start = bytes_accepted;
    while (bytes_accepted - start < RANDOM_BYTES) begin
      case (phase % 4)
        0:       size = 8;
        1:       size = 16;
        2:       size = 32;
        default: size = $urandom_range(1) ? 32 : $urandom_range(0, 32);
      endcase
      kind = (size == 32 && $urandom_range(1)) ? KIND_FLOAT : $urandom_range(0, 3);
      set_config(size, kind,
                 ($urandom_range(3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4),
                 $urandom_range(9) != 0);
      // Phases four to six run without any idling on either side.
      idle_on <= !(phase >= 4 && phase < 7);
      frame_bytes = effective_channels() * bytes_per_sample(size_reg);
      repeat ($urandom_range(4, 10)) begin
        if (frame_bytes == 0 || $urandom_range(3) == 0)
          send_buffer(0, $urandom_range(1, 12));
        else if ($urandom_range(4) == 0)
          send_buffer($urandom_range(0, 2),
                      (frame_bytes > 1) ? $urandom_range(1, frame_bytes - 1) : 1);
        else
          send_buffer($urandom_range(1, 3), 0);
      end
      phase++;
    end
    idle_on <= 1'b1;
  endtask

  initial begin
    rst         = 1'b1;
    size_reg    = SAMPLE_SIZE_RESET;
    kind_reg    = SAMPLE_KIND_RESET;
    chans_reg   = CHANNEL_COUNT_RESET;
    capture_reg = 1'b0;
    shift_acc   = '0;
    byte_pos    = '0;
    chan_pos    = '0;
    frame_max   = '0;
    buffer_max  = '0;
    level_held  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_state;
    test_signed_bytes;
    test_channel_counts;
    test_float_sample;
    test_metering_off;
    test_size_change_mid_buffer;
    test_output_backpressure;
    test_random_traffic;
    wait_idle;
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/apm_pkg.sv
src/apm_queue.sv
src/apm_front.sv
src/apm_back.sv
src/audio_peak_level_meter.sv
tb/testbench.sv
